// ----- hdl/frsg_pkg.sv -----
`default_nettype none

package frsg_pkg;

    localparam int RATE_INT_BITS        = 10;
    localparam int RATE_FRAC_BITS_DEF   = 16;
    localparam int CREDIT_FRAC_BITS_DEF = 32;
    localparam int INTERVAL_BITS_DEF    = 32;

    typedef enum logic
    {
        PACE_CREDIT = 1'b0,
        PACE_EVEN   = 1'b1
    } pace_mode_t;

    // Divider status toward the controller
    typedef struct packed
    {
        logic done;
        logic rem_nz;
    } frsg_div_stat_t;

endpackage

`default_nettype wire

// ----- hdl/frsg_div.sv -----
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
// Integer form (int_mode=1): num / den over RW steps, numerator shifted in.
// Fraction form (int_mode=0): num * 2^CFB / den over CFB steps, needs num < den.
module frsg_div #(
    parameter int RW  = 26,
    parameter int CFB = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   int_mode,
    input  wire logic [RW-1:0]          num,
    input  wire logic [RW-1:0]          den,
    output logic [((CFB > RW) ? CFB : RW)-1:0] quotient,
    output frsg_pkg::frsg_div_stat_t    stat
);
    import frsg_pkg::*;

    localparam int QW   = (CFB > RW) ? CFB : RW;
    localparam int CNTW = $clog2(QW + 1);

    logic [RW-1:0]   r_reg, r_next;
    logic [RW-1:0]   n_reg, n_next;
    logic [RW-1:0]   d_reg, d_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [RW:0]     trial;
    logic            ge;

    always_comb
    begin
        trial     = {r_reg, n_reg[RW-1]};
        ge        = (trial >= {1'b0, d_reg});
        r_next    = r_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            d_next    = den;
            q_next    = '0;
            busy_next = 1'b1;
            if (int_mode)
            begin
                r_next   = '0;
                n_next   = num;
                cnt_next = CNTW'(RW);
            end
            else
            begin
                r_next   = num;
                n_next   = '0;
                cnt_next = CNTW'(CFB);
            end
        end
        else if (busy_reg)
        begin
            r_next   = ge ? RW'(trial - {1'b0, d_reg}) : trial[RW-1:0];
            n_next   = {n_reg[RW-2:0], 1'b0};
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        n_reg <= n_next;
        d_reg <= d_next;
        q_reg <= q_next;
    end

    assign quotient    = q_reg;
    assign stat.done   = done_reg;
    assign stat.rem_nz = |r_reg;

endmodule

`default_nettype wire

// ----- hdl/fractional_rate_slot_gate_top.sv -----
`default_nettype none

// Channel   Handshake              Payload
// in        in_valid / in_stall    permit_rate, slot_rate, restart
// out       out_valid / out_stall  allow_slot
// cfg       cfg_we                 cfg_data (pacing mode)
//
// Paced slots go through a bit-serial divider; a new item is taken only once the
// previous one has left the write state. Pass-through and zero-rate slots skip the
// divider and go straight to the write state.
// Reset clears all pacing state and the mode register, and empties the output.
// The output register holds a result while out_stall is high; the next item is
// taken meanwhile and waits for the output register before it is delivered.
module fractional_rate_slot_gate_top #(
    parameter int RATE_FRAC_BITS   = frsg_pkg::RATE_FRAC_BITS_DEF,
    parameter int CREDIT_FRAC_BITS = frsg_pkg::CREDIT_FRAC_BITS_DEF,
    parameter int INTERVAL_BITS    = frsg_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic                                          cfg_we,
    input  wire logic                                          cfg_data,
    input  wire logic                                          in_valid,
    output logic                                               in_stall,
    input  wire logic [frsg_pkg::RATE_INT_BITS+RATE_FRAC_BITS-1:0] permit_rate,
    input  wire logic [frsg_pkg::RATE_INT_BITS+RATE_FRAC_BITS-1:0] slot_rate,
    input  wire logic                                          restart,
    output logic                                               out_valid,
    input  wire logic                                          out_stall,
    output logic                                               allow_slot
);
    import frsg_pkg::*;

    localparam int RW  = RATE_INT_BITS + RATE_FRAC_BITS;
    localparam int CFB = CREDIT_FRAC_BITS;
    localparam int IB  = INTERVAL_BITS;
    localparam int QW  = (CFB > RW) ? CFB : RW;
    localparam int CW  = CFB + 2;
    localparam int EW  = ((RW > IB) ? RW : IB) + 1;

    localparam logic [CW-1:0] CREDIT_ONE   = CW'(1) << CFB;
    localparam logic [EW-1:0] INTERVAL_MAX = {{(EW-IB){1'b0}}, {IB{1'b1}}};

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_WRITE
    } state_t;

    state_t          state_reg, state_next;
    pace_mode_t      mode_reg, mode_next;
    logic [CW-1:0]   credit_reg, credit_next;
    logic            credit_started_reg, credit_started_next;
    logic [IB-1:0]   phase_reg, phase_next;
    logic [IB-1:0]   interval_reg, interval_next;
    logic            interval_started_reg, interval_started_next;
    logic            res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    logic            allow_reg, allow_next;

    logic            accept;
    logic            pass;
    logic            div_start;
    logic [QW-1:0]   quotient;
    frsg_div_stat_t  div_stat;

    logic [CW-1:0]   ratio;
    logic [CW-1:0]   credit_sum;
    logic [CW-1:0]   credit_left;
    logic [EW-1:0]   interval_raw;
    logic [IB-1:0]   interval_c;
    logic [IB-1:0]   phase_base;
    logic [IB:0]     phase_inc;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign pass      = (slot_rate == '0) || (permit_rate >= slot_rate);
    assign div_start = accept && !pass && (permit_rate != '0);

    frsg_div #(
        .RW  (RW),
        .CFB (CFB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .int_mode (mode_reg == PACE_EVEN),
        .num      ((mode_reg == PACE_EVEN) ? slot_rate : permit_rate),
        .den      ((mode_reg == PACE_EVEN) ? permit_rate : slot_rate),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Credit path: a fresh credit plus the ratio is exactly one
    always_comb
    begin
        ratio       = CW'(quotient[CFB-1:0]);
        credit_sum  = credit_started_reg ? (credit_reg + ratio) : CREDIT_ONE;
        credit_left = credit_sum - CREDIT_ONE;
        if (credit_left > CREDIT_ONE)
        begin
            credit_left = CREDIT_ONE;
        end
    end

    // Even path: ceiling of the quotient, clamped to one and the interval range
    always_comb
    begin
        interval_raw = EW'(quotient[RW-1:0]) + EW'(div_stat.rem_nz);
        if (interval_raw > INTERVAL_MAX)
        begin
            interval_c = IB'(INTERVAL_MAX);
        end
        else if (interval_raw == '0)
        begin
            interval_c = IB'(1);
        end
        else
        begin
            interval_c = interval_raw[IB-1:0];
        end
        phase_base = (!interval_started_reg || (interval_reg != interval_c)) ? '0 : phase_reg;
        phase_inc  = {1'b0, phase_base} + (IB+1)'(1);
    end

    always_comb
    begin
        state_next            = state_reg;
        mode_next             = mode_reg;
        credit_next           = credit_reg;
        credit_started_next   = credit_started_reg;
        phase_next            = phase_reg;
        interval_next         = interval_reg;
        interval_started_next = interval_started_reg;
        res_next              = res_reg;
        out_valid_next        = out_valid_reg;
        allow_next            = allow_reg;

        if (cfg_we)
        begin
            mode_next = pace_mode_t'(cfg_data);
        end

        // drop the delivered item
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (restart)
                    begin
                        credit_next           = '0;
                        credit_started_next   = 1'b0;
                        phase_next            = '0;
                        interval_next         = '0;
                        interval_started_next = 1'b0;
                    end
                    if (pass)
                    begin
                        if (mode_reg == PACE_EVEN)
                        begin
                            phase_next            = '0;
                            interval_next         = '0;
                            interval_started_next = 1'b0;
                        end
                        else
                        begin
                            credit_next         = '0;
                            credit_started_next = 1'b0;
                        end
                        res_next   = 1'b1;
                        state_next = ST_WRITE;
                    end
                    else if (permit_rate == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    if (mode_reg == PACE_EVEN)
                    begin
                        interval_next         = interval_c;
                        interval_started_next = 1'b1;
                        res_next              = (phase_base == '0);
                        phase_next            = (phase_inc >= {1'b0, interval_c}) ?
                                                '0 : phase_inc[IB-1:0];
                    end
                    else
                    begin
                        credit_started_next = 1'b1;
                        if (credit_sum < CREDIT_ONE)
                        begin
                            credit_next = credit_sum;
                            res_next    = 1'b0;
                        end
                        else
                        begin
                            credit_next = credit_left;
                            res_next    = 1'b1;
                        end
                    end
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    allow_next     = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            mode_reg             <= PACE_CREDIT;
            credit_reg           <= '0;
            credit_started_reg   <= 1'b0;
            phase_reg            <= '0;
            interval_reg         <= '0;
            interval_started_reg <= 1'b0;
            res_reg              <= 1'b0;
            out_valid_reg        <= 1'b0;
            allow_reg            <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            mode_reg             <= mode_next;
            credit_reg           <= credit_next;
            credit_started_reg   <= credit_started_next;
            phase_reg            <= phase_next;
            interval_reg         <= interval_next;
            interval_started_reg <= interval_started_next;
            res_reg              <= res_next;
            out_valid_reg        <= out_valid_next;
            allow_reg            <= allow_next;
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign allow_slot = allow_reg;

endmodule

`default_nettype wire

// ----- test/frsg_slot_checker.sv -----
`timescale 1ns / 1ps

module frsg_slot_checker
(
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    cfg_we,
    input  logic                                                    cfg_data,
    input  logic                                                    in_valid,
    input  logic                                                    in_stall,
    input  logic [frsg_pkg::RATE_INT_BITS+frsg_pkg::RATE_FRAC_BITS_DEF-1:0] permit_rate,
    input  logic [frsg_pkg::RATE_INT_BITS+frsg_pkg::RATE_FRAC_BITS_DEF-1:0] slot_rate,
    input  logic                                                    restart,
    input  logic                                                    out_valid,
    input  logic                                                    out_stall,
    input  logic                                                    allow_slot,
    output int                                                      fail_count,
    output int                                                      pending,
    output int                                                      slots_judged,
    output int                                                      slots_allowed
);
    import frsg_pkg::*;

    localparam int          RW        = RATE_INT_BITS + RATE_FRAC_BITS_DEF;
    localparam int          CFB       = CREDIT_FRAC_BITS_DEF;
    localparam int          IB        = INTERVAL_BITS_DEF;
    localparam int          EXP_DEPTH = 8;
    localparam logic [63:0] CREDIT_1  = 64'd1 << CFB;
    localparam logic [63:0] IVAL_MAX  = (64'd1 << IB) - 64'd1;

    pace_mode_t    mode_q;
    logic [CFB+1:0] credit_q;
    logic          credit_live;
    logic [IB-1:0] phase_q;
    logic [IB-1:0] ival_q;
    logic          ival_live;
    logic          expected_allow[EXP_DEPTH];
    int            wr_ptr;
    int            rd_ptr;

    function automatic void clear_credit();
        credit_q    = '0;
        credit_live = 1'b0;
    endfunction

    function automatic void clear_even();
        phase_q   = '0;
        ival_q    = '0;
        ival_live = 1'b0;
    endfunction

    // Decide one slot and advance the pacing state
    function automatic logic judge_slot(input logic [RW-1:0] a, input logic [RW-1:0] t,
                                        input logic rs);
        logic [63:0] ratio;
        logic [63:0] acc;
        logic [63:0] ival;
        logic [63:0] nxt;
        logic        ok;
        if (rs)
        begin
            clear_credit();
            clear_even();
        end
        if (t == '0 || a >= t)
        begin
            if (mode_q == PACE_EVEN)
                clear_even();
            else
                clear_credit();
            ok = 1'b1;
        end
        else if (a == '0)
        begin
            ok = 1'b0;
        end
        else if (mode_q == PACE_EVEN)
        begin
            ival = 64'(t) / 64'(a);
            if (64'(t) % 64'(a) != 64'd0)
                ival = ival + 64'd1;
            if (ival < 64'd1)
                ival = 64'd1;
            if (ival > IVAL_MAX)
                ival = IVAL_MAX;
            if (!ival_live || ival_q != ival[IB-1:0])
            begin
                phase_q   = '0;
                ival_q    = ival[IB-1:0];
                ival_live = 1'b1;
            end
            ok      = (phase_q == '0);
            nxt     = 64'(phase_q) + 64'd1;
            phase_q = (nxt >= 64'(ival_q)) ? '0 : nxt[IB-1:0];
        end
        else
        begin
            ratio = (64'(a) << CFB) / 64'(t);
            // seed so that the first paced slot is allowed
            if (!credit_live)
            begin
                credit_q    = (CFB+2)'(CREDIT_1 - ratio);
                credit_live = 1'b1;
            end
            acc = 64'(credit_q) + ratio;
            if (acc < CREDIT_1)
            begin
                ok = 1'b0;
            end
            else
            begin
                acc = acc - CREDIT_1;
                if (acc > CREDIT_1)
                    acc = CREDIT_1;
                ok = 1'b1;
            end
            credit_q = acc[CFB+1:0];
        end
        return ok;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic want;
        if (!rst_n)
        begin
            mode_q = PACE_CREDIT;
            clear_credit();
            clear_even();
            wr_ptr        = 0;
            rd_ptr        = 0;
            fail_count    = 0;
            pending       = 0;
            slots_judged  = 0;
            slots_allowed = 0;
        end
        else
        begin
            // compare first: a result never belongs to an item taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (wr_ptr == rd_ptr)
                begin
                    if (fail_count < 10)
                        $display("%0t: allow_slot=%0b delivered with no slot outstanding",
                                 $realtime, allow_slot);
                    fail_count++;
                end
                else
                begin
                    want = expected_allow[rd_ptr % EXP_DEPTH];
                    rd_ptr++;
                    if (allow_slot !== want)
                    begin
                        if (fail_count < 10)
                            $display("%0t: allow_slot mismatch, expected %0b got %0b",
                                     $realtime, want, allow_slot);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                mode_q = pace_mode_t'(cfg_data);
            if (in_valid && !in_stall)
            begin
                want = judge_slot(permit_rate, slot_rate, restart);
                expected_allow[wr_ptr % EXP_DEPTH] = want;
                wr_ptr++;
                slots_judged++;
                if (want)
                    slots_allowed++;
            end
            pending = wr_ptr - rd_ptr;
        end
    end

endmodule

// ----- test/tb_fractional_rate_slot_gate_top.sv -----
`timescale 1ns / 1ps

module tb_fractional_rate_slot_gate_top;

    import frsg_pkg::*;

    localparam int          RW       = RATE_INT_BITS + RATE_FRAC_BITS_DEF;
    localparam logic [RW-1:0] RATE_MAX = '1;
    localparam logic [RW-1:0] RATE_ONE = RW'(1) << RATE_FRAC_BITS_DEF;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic          cfg_data;
    logic          in_valid;
    logic          in_stall;
    logic [RW-1:0] permit_rate;
    logic [RW-1:0] slot_rate;
    logic          restart;
    logic          out_valid;
    logic          out_stall;
    logic          allow_slot;

    int fail_count;
    int pending;
    int slots_judged;
    int slots_allowed;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    fractional_rate_slot_gate_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .permit_rate  (permit_rate),
        .slot_rate    (slot_rate),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .allow_slot   (allow_slot)
    );

    frsg_slot_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .permit_rate   (permit_rate),
        .slot_rate     (slot_rate),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .allow_slot    (allow_slot),
        .fail_count    (fail_count),
        .pending       (pending),
        .slots_judged  (slots_judged),
        .slots_allowed (slots_allowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Entered and left at a falling edge; the item stays up until taken
    task automatic send_slot(input logic [RW-1:0] a, input logic [RW-1:0] t,
                             input logic rs);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        permit_rate <= a;
        slot_rate   <= t;
        restart     <= rs;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Hold off the sender until every slot has been answered
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input pace_mode_t m);
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_directed();
        send_slot('0, '0, 1'b0);
        send_slot(RATE_MAX, '0, 1'b0);
        send_slot(RATE_MAX, RATE_MAX, 1'b0);
        send_slot('0, RATE_MAX, 1'b0);
        send_slot(RW'(1), RATE_MAX, 1'b0);
        send_slot(RATE_MAX - RW'(1), RATE_MAX, 1'b0);
        send_slot(RATE_ONE, RATE_ONE * RW'(3), 1'b0);
        send_slot(RATE_ONE, RATE_ONE * RW'(3), 1'b0);
        send_slot(RATE_ONE, RATE_ONE * RW'(3), 1'b0);
        send_slot(RATE_ONE, RATE_ONE * RW'(3), 1'b1);
        send_slot(RATE_MAX, RW'(1), 1'b0);
    endtask

    task automatic send_random(input int n);
        int            sent;
        int            len;
        int            k;
        logic [RW-1:0] a;
        logic [RW-1:0] t;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(99) < 72)
            begin
                // steady rate pair for a run of slots so credit and phase build up
                t = $urandom_range(1) ? RW'($urandom) : RW'($urandom_range(2, 5000));
                if (t < RW'(2))
                    t = RW'(2);
                if ($urandom_range(3) == 0)
                begin
                    a = RW'($urandom_range(1, 32'(t) - 32'd1));
                end
                else
                begin
                    k = $urandom_range(2, 12);
                    a = t / RW'(k);
                    if (a == '0)
                        a = RW'(1);
                end
                len = $urandom_range(1, 24);
                repeat (len)
                begin
                    send_slot(a, t, $urandom_range(39) == 0);
                    sent++;
                end
            end
            else
            begin
                a = RW'($urandom);
                t = RW'($urandom);
                case ($urandom_range(3))
                    0: t = '0;
                    1: if (a < t) {a, t} = {t, a};
                    2: a = '0;
                    default: ;
                endcase
                send_slot(a, t, 1'($urandom_range(1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_data    = 1'b0;
        in_valid    = 1'b0;
        permit_rate = '0;
        slot_rate   = '0;
        restart     = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_mode(PACE_CREDIT);
        run_directed();
        drain();
        write_mode(PACE_EVEN);
        run_directed();
        drain();

        for (int p = 0; p < 3; p++)
        begin
            send_gap_pct   = (p == 0) ? 24 : (p == 1) ? 47 : 0;
            recv_stall_pct = (p == 0) ? 47 : (p == 1) ? 24 : 0;
            for (int seg = 0; seg < 4; seg++)
            begin
                write_mode(pace_mode_t'((seg + p) % 2));
                send_random(135);
                drain();
            end
        end

        repeat (50) @(negedge clk);
        $display("covered %0d slots (%0d allowed) in credit and even pacing,",
                 slots_judged, slots_allowed);
        $display("with gaps and stalls on both channels and a stretch without either");
        if (fail_count == 0 && pending == 0)
            $display("tb_fractional_rate_slot_gate_top: done, clean");
        else
            $display("tb_fractional_rate_slot_gate_top: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_fractional_rate_slot_gate_top: done, errors");
        $finish;
    end

endmodule
